@@ rtl/core/sha_pkg.sv @@
package sha_pkg;

	// default geometry
	localparam int SLAB_SLOTS_DEF = 64;
	localparam int MAX_SLABS_DEF  = 16;

	// fixed field widths
	localparam int HANDLE_W = 10;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 11;
	localparam int SLABS_W  = 5;

	// request opcodes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_LIVE  = 2'd2;

	// entries in the front-to-back queue
	localparam int QUEUE_DEPTH = 2;

	// classified request as it sits in the queue
	typedef struct packed {
		logic                op;
		logic [HANDLE_W-1:0] free_handle;
		logic                in_range;
	} sha_item_t;

	// queue head seen by the back end
	typedef struct packed {
		logic      valid;
		sha_item_t item;
	} sha_head_t;

	// back end control seen by the front end
	typedef struct packed {
		logic pop;
		logic clearing;
	} sha_back_ctl_t;

endpackage

@@ rtl/core/slab_handle_allocator.sv @@
// Handle allocator: each op=0 beat returns a handle, recycled LIFO from the
// free stack when it holds any, else the next slot of the current slab (a new
// slab is opened when none is open or the current one is full). Each op=1 beat
// returns free_handle to the stack. Exactly one result beat per request, in
// order. Status 1 means every slab is open and full with nothing to recycle;
// status 2 means the freed handle is out of range or not live. Neither error
// changes any state. After reset the block clears its live bitmap, one entry
// per cycle, over all SLAB_SLOTS*MAX_SLABS entries (1024 by default), with
// in_stall held high. Each request then runs in the back end as a registered
// read of the live bitmap / free stack memory, then a commit into the output
// register. A 2-beat queue in front absorbs input bursts. While a result
// is stalled, the next request can do its read but not yet its commit.

module slab_handle_allocator import sha_pkg::*; #(
	parameter int SLAB_SLOTS = SLAB_SLOTS_DEF,
	parameter int MAX_SLABS  = MAX_SLABS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// request channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                op,
	input  logic [HANDLE_W-1:0] free_handle,
	// result channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic [HANDLE_W-1:0] given_handle,
	output logic [STATUS_W-1:0] status,
	output logic                was_recycled,
	output logic [COUNT_W-1:0]  live_count,
	output logic [SLABS_W-1:0]  slabs_opened
);

	sha_head_t     head;
	sha_back_ctl_t ctl;

	// front: accepts beats, decodes op and range-checks the handle, queues
	sha_front #(
		.SLAB_SLOTS (SLAB_SLOTS),
		.MAX_SLABS  (MAX_SLABS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.free_handle (free_handle),
		.head        (head),
		.ctl         (ctl)
	);

	// back: free stack, live bitmap, bump pointer, result register
	sha_back #(
		.SLAB_SLOTS (SLAB_SLOTS),
		.MAX_SLABS  (MAX_SLABS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.ctl          (ctl),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.given_handle (given_handle),
		.status       (status),
		.was_recycled (was_recycled),
		.live_count   (live_count),
		.slabs_opened (slabs_opened)
	);

endmodule

@@ rtl/core/sha_front.sv @@
module sha_front import sha_pkg::*; #(
	parameter int SLAB_SLOTS = SLAB_SLOTS_DEF,
	parameter int MAX_SLABS  = MAX_SLABS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                op,
	input  logic [HANDLE_W-1:0] free_handle,
	output sha_head_t           head,
	input  sha_back_ctl_t       ctl
);

	localparam int POOL_SIZE = SLAB_SLOTS * MAX_SLABS;
	localparam int QAW       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW       = $clog2(QUEUE_DEPTH + 1);

	sha_item_t        q_mem [QUEUE_DEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   count_q;
	logic             push;
	logic             pop;
	sha_item_t        new_item;

	// classify: range check against the pool size
	always_comb begin
		new_item.op          = op;
		new_item.free_handle = free_handle;
		new_item.in_range    = 32'(free_handle) < 32'(POOL_SIZE);
	end

	assign in_stall = (count_q == QCW'(QUEUE_DEPTH)) || ctl.clearing;
	assign push     = in_valid && !in_stall;
	assign pop      = ctl.pop;

	assign head.valid = count_q != '0;
	assign head.item  = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QAW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCW'(1);
				2'b01:   count_q <= count_q - QCW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/core/sha_back.sv @@
module sha_back import sha_pkg::*; #(
	parameter int SLAB_SLOTS = SLAB_SLOTS_DEF,
	parameter int MAX_SLABS  = MAX_SLABS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sha_head_t           head,
	output sha_back_ctl_t       ctl,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [HANDLE_W-1:0] given_handle,
	output logic [STATUS_W-1:0] status,
	output logic                was_recycled,
	output logic [COUNT_W-1:0]  live_count,
	output logic [SLABS_W-1:0]  slabs_opened
);

	localparam int POOL_SIZE = SLAB_SLOTS * MAX_SLABS;
	localparam int HW        = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam int DW        = $clog2(POOL_SIZE + 1);
	localparam int SW        = $clog2(MAX_SLABS + 1);
	localparam int FW        = $clog2(SLAB_SLOTS + 1);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_EXEC  = 2'd2;

	// memories
	logic          live_mem [POOL_SIZE];
	logic [HW-1:0] stk_mem  [POOL_SIZE];

	logic [1:0]    state_q;
	logic [HW-1:0] clr_cnt_q;
	logic [DW-1:0] depth_q;
	logic [DW-1:0] inuse_q;
	logic [FW-1:0] fresh_q;
	logic [SW-1:0] slab_q;
	logic [HW-1:0] base_q;

	sha_item_t     cur_s1;
	logic          live_rd_s1;
	logic [HW-1:0] stk_rd_s1;

	logic                out_valid_q;
	logic [HANDLE_W-1:0] given_handle_q;
	logic [STATUS_W-1:0] status_q;
	logic                was_recycled_q;
	logic [COUNT_W-1:0]  live_count_q;
	logic [SLABS_W-1:0]  slabs_opened_q;

	logic          slot_free;
	logic          pop;
	logic          commit;
	logic [HW-1:0] rd_handle;
	logic [HW-1:0] stk_raddr;
	logic [HW-1:0] cur_hnd;
	logic          need_slab;
	logic          pool_full;
	logic [HW-1:0] base_eff;
	logic [FW-1:0] fresh_eff;
	logic [HW-1:0] fresh_hnd;

	logic [DW-1:0] depth_n;
	logic [DW-1:0] inuse_n;
	logic [FW-1:0] fresh_n;
	logic [SW-1:0] slab_n;
	logic [HW-1:0] base_n;
	logic [HW-1:0] res_handle;
	logic [STATUS_W-1:0] res_status;
	logic          res_recyc;
	logic          live_we;
	logic [HW-1:0] live_wa;
	logic          live_wd;
	logic          stk_we;

	assign slot_free = !out_valid_q || !out_stall;
	assign pop       = (state_q == S_IDLE) && head.valid;
	assign commit    = (state_q == S_EXEC) && slot_free;
	assign rd_handle = HW'(head.item.free_handle);
	assign stk_raddr = HW'(depth_q - DW'(1));
	assign cur_hnd   = HW'(cur_s1.free_handle);

	assign ctl.pop      = pop;
	assign ctl.clearing = state_q == S_CLEAR;

	// bump allocator: open a slab when none is open or the current one is full
	always_comb begin
		need_slab = (slab_q == '0) || (fresh_q >= FW'(SLAB_SLOTS));
		pool_full = slab_q >= SW'(MAX_SLABS);
		if (!need_slab) begin
			base_eff = base_q;
		end else if (slab_q == '0) begin
			base_eff = '0;
		end else begin
			base_eff = base_q + HW'(SLAB_SLOTS);
		end
		fresh_eff = need_slab ? '0 : fresh_q;
		fresh_hnd = base_eff + HW'(fresh_eff);
	end

	always_comb begin
		depth_n    = depth_q;
		inuse_n    = inuse_q;
		fresh_n    = fresh_q;
		slab_n     = slab_q;
		base_n     = base_q;
		res_handle = '0;
		res_status = ST_OK;
		res_recyc  = 1'b0;
		live_we    = 1'b0;
		live_wa    = clr_cnt_q;
		live_wd    = 1'b0;
		stk_we     = 1'b0;
		if (state_q == S_CLEAR) begin
			live_we = 1'b1;
		end else if (commit) begin
			if (cur_s1.op == OP_ALLOC) begin
				if (depth_q != '0) begin
					depth_n    = depth_q - DW'(1);
					res_handle = stk_rd_s1;
					res_recyc  = 1'b1;
					live_we    = 1'b1;
					live_wa    = stk_rd_s1;
					live_wd    = 1'b1;
					inuse_n    = inuse_q + DW'(1);
				end else if (need_slab && pool_full) begin
					res_status = ST_EXHAUSTED;
				end else begin
					slab_n     = need_slab ? slab_q + SW'(1) : slab_q;
					base_n     = base_eff;
					fresh_n    = fresh_eff + FW'(1);
					res_handle = fresh_hnd;
					live_we    = 1'b1;
					live_wa    = fresh_hnd;
					live_wd    = 1'b1;
					inuse_n    = inuse_q + DW'(1);
				end
			end else begin
				if (!cur_s1.in_range || !live_rd_s1 || depth_q >= DW'(POOL_SIZE)) begin
					res_status = ST_NOT_LIVE;
				end else begin
					live_we = 1'b1;
					live_wa = cur_hnd;
					live_wd = 1'b0;
					stk_we  = 1'b1;
					depth_n = depth_q + DW'(1);
					inuse_n = (inuse_q != '0) ? inuse_q - DW'(1) : inuse_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (live_we) begin
			live_mem[live_wa] <= live_wd;
		end
		if (pop) begin
			live_rd_s1 <= live_mem[rd_handle];
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[HW'(depth_q)] <= cur_hnd;
		end
		if (pop && depth_q != '0) begin
			stk_rd_s1 <= stk_mem[stk_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_s1 <= head.item;
		end
		if (commit) begin
			given_handle_q <= HANDLE_W'(res_handle);
			status_q       <= res_status;
			was_recycled_q <= res_recyc;
			live_count_q   <= COUNT_W'(inuse_n);
			slabs_opened_q <= SLABS_W'(slab_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_cnt_q   <= '0;
			depth_q     <= '0;
			inuse_q     <= '0;
			fresh_q     <= '0;
			slab_q      <= '0;
			base_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			depth_q <= depth_n;
			inuse_q <= inuse_n;
			fresh_q <= fresh_n;
			slab_q  <= slab_n;
			base_q  <= base_n;
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + HW'(1);
					if (clr_cnt_q == HW'(POOL_SIZE - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (pop) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign given_handle = given_handle_q;
	assign status       = status_q;
	assign was_recycled = was_recycled_q;
	assign live_count   = live_count_q;
	assign slabs_opened = slabs_opened_q;

endmodule

@@ rtl/core/sha_checker.sv @@
module sha_checker import sha_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic [HANDLE_W-1:0] given_handle,
	input logic [STATUS_W-1:0] status,
	input logic                was_recycled,
	input logic [COUNT_W-1:0]  live_count,
	input logic [SLABS_W-1:0]  slabs_opened
);

	logic [COUNT_W-1:0] last_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_count_q <= '0;
		end else if (out_valid && !out_stall) begin
			last_count_q <= live_count;
		end
	end

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(given_handle) && $stable(status)
			&& $stable(was_recycled) && $stable(live_count) && $stable(slabs_opened))
		else $error("stalled result beat changed");

	// an error result carries no handle
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> given_handle == '0 && !was_recycled)
		else $error("error result carries a handle");

	// bitmap clear pass blocks input right after reset
	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> in_stall)
		else $error("input taken during clear pass");

	// live count moves by at most one per result
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> live_count == last_count_q
			|| live_count == last_count_q + COUNT_W'(1)
			|| live_count == last_count_q - COUNT_W'(1))
		else $error("live count jumped");

endmodule

bind slab_handle_allocator sha_checker u_sha_checker (.*);
